// ----- design/fsds_pkg.sv -----
// fsds_pkg: shared types and constants for the fan speed deadband stepper
// no dependencies; used by fan_speed_deadband_stepper
`default_nettype none

package fsds_pkg;

    // transaction command codes
    typedef enum logic [1:0] {
        CMD_PULSE  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TARGET = 2'd2
    } t_cmd;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPP      = 2'd1;
    localparam int unsigned CFG_DATA_W = 10;

    // field widths
    localparam int unsigned DEADBAND_W = 10;
    localparam int unsigned RPP_W      = 8;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned DUTY_W     = 10;

    // defaults
    localparam int unsigned COUNT_WIDTH_DEF = 11;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 10'd40;
    localparam logic [RPP_W-1:0]      RPP_RESET      = 8'd30;
    localparam logic [SPEED_W-1:0]    TARGET_RESET   = 16'd6000;
    localparam logic [DUTY_W-1:0]     DUTY_RESET     = 10'd278;

    // duty limits and preload window
    localparam logic [DUTY_W-1:0]  DUTY_MAX        = 10'd1000;
    localparam logic [SPEED_W-1:0] PRELOAD_LOW_RPM  = 16'd240;
    localparam logic [SPEED_W-1:0] PRELOAD_HIGH_RPM = 16'd8000;

    // linear map duty = (MAP_OFFSET - MAP_SLOPE*rpm) / 83707, fixed point
    // the divide is an exact multiply by ceil(2^44/83707) for numerators < 2^27
    localparam int unsigned MAP_NUM_W   = 27;
    localparam int unsigned MAP_SCALE_W = 30;
    localparam logic [MAP_SCALE_W-1:0] MAP_OFFSET = 30'd83329000;
    localparam logic [13:0]            MAP_SLOPE  = 14'd10000;
    localparam int unsigned MAP_RECIP_W = 28;
    localparam logic [MAP_RECIP_W-1:0] MAP_RECIP  = 28'd210163858;
    localparam int unsigned MAP_SHIFT   = 44;

endpackage

`default_nettype wire

// ----- design/fan_speed_deadband_stepper.sv -----
// fan_speed_deadband_stepper: tach counter, speed measurement and duty stepper
// depends on fsds_pkg for command codes, widths and constants
`default_nettype none

// a transaction passes the input register, then the state and result register
// throughput: one transaction per cycle while results are taken; with i_out_ready
// low the result register holds, and then the input register holds as well
// reset (synchronous, active low): pipeline empty, count and speed zero,
// target 6000 rpm, duty 278, deadband 40, rpm per pulse 30
module fan_speed_deadband_stepper #(
    parameter int unsigned COUNT_WIDTH = fsds_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [fsds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fsds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_command,
    input  wire logic [fsds_pkg::SPEED_W-1:0]       i_target_value,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [fsds_pkg::DUTY_W-1:0]             o_duty,
    output logic [fsds_pkg::SPEED_W-1:0]            o_speed
);

    localparam int unsigned PROD_W =
        (COUNT_WIDTH + fsds_pkg::RPP_W > fsds_pkg::SPEED_W + 1) ?
        (COUNT_WIDTH + fsds_pkg::RPP_W) : (fsds_pkg::SPEED_W + 1);
    localparam int unsigned MUL_W = fsds_pkg::MAP_NUM_W + fsds_pkg::MAP_RECIP_W;

    // configuration registers
    logic [fsds_pkg::DEADBAND_W-1:0] r_deadband;
    logic [fsds_pkg::RPP_W-1:0]      r_rpp;

    // input stage
    logic                            r_in_valid;
    fsds_pkg::t_cmd                  r_cmd;
    logic [fsds_pkg::SPEED_W-1:0]    r_tval;

    // state, also the result register
    logic                            r_out_valid;
    logic [COUNT_WIDTH-1:0]          r_count;
    logic [fsds_pkg::SPEED_W-1:0]    r_speed;
    logic [fsds_pkg::SPEED_W-1:0]    r_target;
    logic [fsds_pkg::DUTY_W-1:0]     r_duty;

    logic [COUNT_WIDTH-1:0]          n_count;
    logic [fsds_pkg::SPEED_W-1:0]    n_speed;
    logic [fsds_pkg::SPEED_W-1:0]    n_target;
    logic [fsds_pkg::DUTY_W-1:0]     n_duty;

    logic                            w_advance;
    logic                            w_in_fire;
    logic [PROD_W-1:0]               w_prod;
    logic [fsds_pkg::SPEED_W-1:0]    w_meas;
    logic [fsds_pkg::SPEED_W:0]      w_spd_ext;
    logic [fsds_pkg::SPEED_W:0]      w_tgt_ext;
    logic [fsds_pkg::SPEED_W:0]      w_band_ext;
    logic [fsds_pkg::MAP_SCALE_W-1:0] w_scaled;
    logic [fsds_pkg::MAP_NUM_W-1:0]  w_num;
    logic [MUL_W-1:0]                w_quot_full;
    logic [fsds_pkg::DUTY_W-1:0]     w_preload;

    // handshake: stage two moves when the result slot is free or being taken
    assign w_advance   = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_speed     = r_speed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= fsds_pkg::DEADBAND_RESET;
            r_rpp      <= fsds_pkg::RPP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fsds_pkg::CFG_DEADBAND) begin
                r_deadband <= i_cfg_data[fsds_pkg::DEADBAND_W-1:0];
            end else if (i_cfg_index == fsds_pkg::CFG_RPP) begin
                r_rpp <= i_cfg_data[fsds_pkg::RPP_W-1:0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd  <= fsds_pkg::t_cmd'(i_command);
            r_tval <= i_target_value;
        end
    end

    // measured speed: count times rpm per pulse, saturated
    assign w_prod = PROD_W'(r_count) * PROD_W'(r_rpp);
    assign w_meas = (w_prod > PROD_W'({fsds_pkg::SPEED_W{1'b1}})) ?
                    {fsds_pkg::SPEED_W{1'b1}} : w_prod[fsds_pkg::SPEED_W-1:0];

    // deadband compare at 17 bits so no sum wraps
    assign w_spd_ext  = {1'b0, w_meas};
    assign w_tgt_ext  = {1'b0, r_target};
    assign w_band_ext = (fsds_pkg::SPEED_W + 1)'(r_deadband);

    // duty preload: linear map inside the window, exact reciprocal divide
    assign w_scaled    = fsds_pkg::MAP_OFFSET -
                         (fsds_pkg::MAP_SCALE_W'(r_tval) *
                          fsds_pkg::MAP_SCALE_W'(fsds_pkg::MAP_SLOPE));
    assign w_num       = w_scaled[fsds_pkg::MAP_NUM_W-1:0];
    assign w_quot_full = MUL_W'(w_num) * MUL_W'(fsds_pkg::MAP_RECIP);

    always_comb begin
        if (r_tval < fsds_pkg::PRELOAD_LOW_RPM) begin
            w_preload = fsds_pkg::DUTY_MAX;
        end else if (r_tval > fsds_pkg::PRELOAD_HIGH_RPM) begin
            w_preload = '0;
        end else begin
            w_preload = w_quot_full[fsds_pkg::MAP_SHIFT +: fsds_pkg::DUTY_W];
        end
    end

    // next state per command
    always_comb begin
        n_count  = r_count;
        n_speed  = r_speed;
        n_target = r_target;
        n_duty   = r_duty;
        case (r_cmd)
            fsds_pkg::CMD_PULSE: begin
                if (r_count != {COUNT_WIDTH{1'b1}}) begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
            end
            fsds_pkg::CMD_TICK: begin
                n_speed = w_meas;
                n_count = '0;
                if (w_spd_ext > w_tgt_ext + w_band_ext) begin
                    if (r_duty < fsds_pkg::DUTY_MAX) begin
                        n_duty = r_duty + fsds_pkg::DUTY_W'(1);
                    end
                end else if (w_spd_ext + w_band_ext < w_tgt_ext) begin
                    if (r_duty != '0) begin
                        n_duty = r_duty - fsds_pkg::DUTY_W'(1);
                    end
                end
            end
            fsds_pkg::CMD_TARGET: begin
                n_target = r_tval;
                n_duty   = w_preload;
            end
            default: begin
                // unused code: state holds, result still issued
            end
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_speed     <= '0;
            r_target    <= fsds_pkg::TARGET_RESET;
            r_duty      <= fsds_pkg::DUTY_RESET;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_count  <= n_count;
                r_speed  <= n_speed;
                r_target <= n_target;
                r_duty   <= n_duty;
            end
        end
    end

endmodule

`default_nettype wire
